FILE: hw/rtl/segmented_stack_manager_assert.svh
// assertion macros for the segmented stack manager
`ifndef SEGMENTED_STACK_MANAGER_ASSERT_SVH
`define SEGMENTED_STACK_MANAGER_ASSERT_SVH
`ifndef SYNTH
`define SSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define SSM_ASSERT(label, prop, msg)
`define SSM_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

FILE: hw/rtl/ssm_pkg.sv
// types and codes shared by the segmented stack manager modules
package ssm_pkg;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  stack_id;
        logic [31:0] push_value;
        logic [11:0] depth_offset;
    } req_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [12:0] stack_depth;
        logic [1:0]  status;
    } rsp_t;

    localparam logic [2:0] CMD_OPEN  = 3'd0;
    localparam logic [2:0] CMD_PUSH  = 3'd1;
    localparam logic [2:0] CMD_POP   = 3'd2;
    localparam logic [2:0] CMD_ALLOC = 3'd3;
    localparam logic [2:0] CMD_FSEG  = 3'd4;
    localparam logic [2:0] CMD_FSTK  = 3'd5;
    localparam logic [2:0] CMD_SIZE  = 3'd6;
    localparam logic [2:0] CMD_PEEK  = 3'd7;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_CLOSED = 2'd3;

    localparam logic [4:0] OP_NONE       = 5'd0;
    localparam logic [4:0] OP_INIT       = 5'd1;
    localparam logic [4:0] OP_LATCH      = 5'd2;
    localparam logic [4:0] OP_RD_FH      = 5'd3;
    localparam logic [4:0] OP_TAKE_OPEN  = 5'd4;
    localparam logic [4:0] OP_TAKE_GROW  = 5'd5;
    localparam logic [4:0] OP_PUSH       = 5'd6;
    localparam logic [4:0] OP_RD_TOP     = 5'd7;
    localparam logic [4:0] OP_POP        = 5'd8;
    localparam logic [4:0] OP_RD_BASE    = 5'd9;
    localparam logic [4:0] OP_SHRINK     = 5'd10;
    localparam logic [4:0] OP_FS_START   = 5'd11;
    localparam logic [4:0] OP_RD_B       = 5'd12;
    localparam logic [4:0] OP_FS_GIVE    = 5'd13;
    localparam logic [4:0] OP_WALK_START = 5'd14;
    localparam logic [4:0] OP_WALK_ADD   = 5'd15;
    localparam logic [4:0] OP_WALK_LINK  = 5'd16;
    localparam logic [4:0] OP_SET_DEP    = 5'd17;
    localparam logic [4:0] OP_PK_STEP    = 5'd18;
    localparam logic [4:0] OP_PK_RD      = 5'd19;
    localparam logic [4:0] OP_PK_DATA    = 5'd20;

    typedef struct packed {
        logic [4:0] op;
        logic       st_we;
        logic [1:0] st_val;
        logic       finish;
    } ctl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       sid_ok;
        logic       is_open;
        logic       full;
        logic       empty;
        logic       fh_nil;
        logic       link_nil;
        logic       pk_hit;
        logic       off_ge_n;
        logic       init_last;
    } flg_t;

endpackage

FILE: hw/rtl/ssm_ram.sv
// generic single-write, single-read ram with registered read data
module ssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/ssm_datapath.sv
// datapath: stack registers, free list head, walk registers and the word pool
module ssm_datapath import ssm_pkg::*; #(
    parameter int SEG_WORDS    = 64,
    parameter int NUM_SEGMENTS = 64,
    parameter int NUM_STACKS   = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  req_t request,
    input  ctl_t ctl,
    output flg_t flg,
    output logic done,
    output rsp_t result
);

    localparam int POOL = SEG_WORDS * NUM_SEGMENTS;
    localparam int AW   = $clog2(POOL);
    localparam int PW   = AW + 1;
    localparam int OW   = $clog2(SEG_WORDS);
    localparam int SIW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [PW-1:0] NIL      = PW'(POOL);
    localparam logic [AW-1:0] LAST     = AW'(SEG_WORDS - 1);
    localparam logic [PW-1:0] LASTP    = PW'(SEG_WORDS - 1);
    localparam logic [OW-1:0] OFF_LAST = OW'(SEG_WORDS - 1);
    localparam logic [PW-1:0] SEGP     = PW'(SEG_WORDS);
    localparam logic [AW-1:0] ADDR_END = AW'(POOL - 1);

    logic [AW-1:0]         top_reg  [NUM_STACKS];
    logic [AW-1:0]         top_next [NUM_STACKS];
    logic [AW-1:0]         base_reg [NUM_STACKS];
    logic [AW-1:0]         base_next[NUM_STACKS];
    logic [NUM_STACKS-1:0] open_reg, open_next;
    logic [PW-1:0]         fh_reg, fh_next;
    logic [AW-1:0]         init_addr_reg, init_addr_next;
    logic [OW-1:0]         init_off_reg, init_off_next;
    logic [PW-1:0]         init_nb_reg, init_nb_next;
    logic                  done_reg, done_next;
    logic [PW-1:0]         p_reg, p_next;
    logic [AW-1:0]         b_reg, b_next;
    logic [PW-1:0]         n_reg, n_next;
    logic [11:0]           off_reg, off_next;
    req_t                  req_reg, req_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  sid_ok;
    logic [SIW-1:0]        sidx;
    logic [AW-1:0]         cur_top, cur_base, fh_seg, diff, link_seg;
    logic [PW-1:0]         link;
    logic                  link_nil;
    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [31:0]           wdata, rdata;

    ssm_ram #(
        .WIDTH (32),
        .DEPTH (POOL)
    ) u_pool (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        sid_ok   = 32'(req_reg.stack_id) < NUM_STACKS;
        sidx     = sid_ok ? SIW'(req_reg.stack_id) : '0;
        cur_top  = top_reg[sidx];
        cur_base = base_reg[sidx];
        fh_seg   = fh_reg[AW-1:0];
        diff     = p_reg[AW-1:0] - b_reg;
        link     = (rdata < 32'(POOL)) ? PW'(rdata) : NIL;
        link_nil = link == NIL;
        link_seg = AW'(link - LASTP);

        flg.cmd       = req_reg.command;
        flg.sid_ok    = sid_ok;
        flg.is_open   = open_reg[sidx];
        flg.full      = cur_top == cur_base + LAST;
        flg.empty     = cur_top == cur_base;
        flg.fh_nil    = fh_reg == NIL;
        flg.link_nil  = link_nil;
        flg.pk_hit    = 32'(diff) > 32'(off_reg);
        flg.off_ge_n  = 32'(off_reg) >= 32'(n_reg);
        flg.init_last = init_addr_reg == ADDR_END;
    end

    always_comb
    begin
        top_next       = top_reg;
        base_next      = base_reg;
        open_next      = open_reg;
        fh_next        = fh_reg;
        init_addr_next = init_addr_reg;
        init_off_next  = init_off_reg;
        init_nb_next   = init_nb_reg;
        p_next         = p_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        off_next       = off_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        done_next      = ctl.finish;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        raddr          = '0;

        case (ctl.op)
            OP_INIT:
            begin
                we             = 1'b1;
                waddr          = init_addr_reg;
                wdata          = (init_off_reg == '0) ? 32'(init_nb_reg) : '0;
                init_addr_next = init_addr_reg + 1'b1;
                if (init_off_reg == OFF_LAST)
                begin
                    init_off_next = '0;
                    init_nb_next  = init_nb_reg + SEGP;
                end
                else
                begin
                    init_off_next = init_off_reg + 1'b1;
                end
            end
            OP_LATCH:
            begin
                req_next = request;
                off_next = request.depth_offset;
                rsp_next = '0;
            end
            OP_RD_FH:
            begin
                raddr = fh_seg;
            end
            OP_TAKE_OPEN:
            begin
                we               = 1'b1;
                waddr            = fh_seg;
                wdata            = 32'(NIL);
                fh_next          = link;
                top_next[sidx]   = fh_seg;
                base_next[sidx]  = fh_seg;
                open_next[sidx]  = 1'b1;
            end
            OP_TAKE_GROW:
            begin
                we               = 1'b1;
                waddr            = fh_seg;
                wdata            = 32'(cur_base + LAST);
                fh_next          = link;
                top_next[sidx]   = fh_seg;
                base_next[sidx]  = fh_seg;
            end
            OP_PUSH:
            begin
                we             = 1'b1;
                waddr          = cur_top + 1'b1;
                wdata          = req_reg.push_value;
                top_next[sidx] = cur_top + 1'b1;
            end
            OP_RD_TOP:
            begin
                raddr = cur_top;
            end
            OP_POP:
            begin
                rsp_next.read_value = rdata;
                top_next[sidx]      = cur_top - 1'b1;
            end
            OP_RD_BASE:
            begin
                raddr = cur_base;
            end
            OP_SHRINK:
            begin
                if (!link_nil)
                begin
                    we              = 1'b1;
                    waddr           = cur_base;
                    wdata           = 32'(fh_reg);
                    fh_next         = {1'b0, cur_base};
                    top_next[sidx]  = AW'(link);
                    base_next[sidx] = link_seg;
                end
            end
            OP_FS_START:
            begin
                b_next = cur_base;
            end
            OP_RD_B:
            begin
                raddr = b_reg;
            end
            OP_FS_GIVE:
            begin
                we      = 1'b1;
                waddr   = b_reg;
                wdata   = 32'(fh_reg);
                fh_next = {1'b0, b_reg};
                b_next  = link_seg;
                if (link_nil)
                begin
                    top_next[sidx]  = '0;
                    base_next[sidx] = '0;
                    open_next[sidx] = 1'b0;
                end
            end
            OP_WALK_START:
            begin
                p_next = {1'b0, cur_top};
                b_next = cur_base;
                n_next = '0;
            end
            OP_WALK_ADD:
            begin
                n_next = n_reg + PW'(diff);
                raddr  = b_reg;
            end
            OP_WALK_LINK:
            begin
                p_next = link;
                b_next = link_seg;
            end
            OP_SET_DEP:
            begin
                rsp_next.stack_depth = 13'(n_reg);
            end
            OP_PK_STEP:
            begin
                off_next = off_reg - 12'(diff);
                raddr    = b_reg;
            end
            OP_PK_RD:
            begin
                raddr = AW'(32'(p_reg) - 32'(off_reg));
            end
            OP_PK_DATA:
            begin
                rsp_next.read_value = rdata;
            end
            default:
            begin
            end
        endcase

        if (ctl.st_we)
        begin
            rsp_next.status = ctl.st_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                top_reg[i]  <= '0;
                base_reg[i] <= '0;
            end
            open_reg      <= '0;
            fh_reg        <= '0;
            init_addr_reg <= '0;
            init_off_reg  <= '0;
            init_nb_reg   <= SEGP;
            done_reg      <= 1'b0;
        end
        else
        begin
            top_reg       <= top_next;
            base_reg      <= base_next;
            open_reg      <= open_next;
            fh_reg        <= fh_next;
            init_addr_reg <= init_addr_next;
            init_off_reg  <= init_off_next;
            init_nb_reg   <= init_nb_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        b_reg   <= b_next;
        n_reg   <= n_next;
        off_reg <= off_next;
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

FILE: hw/rtl/ssm_ctrl.sv
// controller state machine sequencing pool accesses for each command
`include "segmented_stack_manager_assert.svh"
module ssm_ctrl import ssm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  flg_t flg,
    output ctl_t ctl,
    output logic busy
);

    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DEC      = 5'd2;
    localparam logic [4:0] S_TK_OPEN  = 5'd3;
    localparam logic [4:0] S_TK_GROW  = 5'd4;
    localparam logic [4:0] S_TK_GROWP = 5'd5;
    localparam logic [4:0] S_PUSH     = 5'd6;
    localparam logic [4:0] S_POP_D    = 5'd7;
    localparam logic [4:0] S_POP_CK   = 5'd8;
    localparam logic [4:0] S_SHR      = 5'd9;
    localparam logic [4:0] S_FS_RD    = 5'd10;
    localparam logic [4:0] S_FS_WR    = 5'd11;
    localparam logic [4:0] S_WALK     = 5'd12;
    localparam logic [4:0] S_WALK_NX  = 5'd13;
    localparam logic [4:0] S_WEND     = 5'd14;
    localparam logic [4:0] S_PK       = 5'd15;
    localparam logic [4:0] S_PK_NX    = 5'd16;
    localparam logic [4:0] S_PK_D     = 5'd17;
    localparam logic [4:0] S_DONE     = 5'd18;

    logic [4:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                ctl.op = OP_INIT;
                if (flg.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op     = OP_LATCH;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_DONE;
                if (!flg.sid_ok)
                begin
                    ctl.st_we  = 1'b1;
                    ctl.st_val = ST_CLOSED;
                end
                else if (flg.cmd == CMD_OPEN)
                begin
                    if (!flg.is_open)
                    begin
                        if (flg.fh_nil)
                        begin
                            ctl.st_we  = 1'b1;
                            ctl.st_val = ST_NOFREE;
                        end
                        else
                        begin
                            ctl.op     = OP_RD_FH;
                            state_next = S_TK_OPEN;
                        end
                    end
                end
                else if (!flg.is_open)
                begin
                    ctl.st_we  = 1'b1;
                    ctl.st_val = ST_CLOSED;
                end
                else
                begin
                    unique case (flg.cmd) inside
                        CMD_PUSH:
                        begin
                            if (!flg.full)
                            begin
                                ctl.op = OP_PUSH;
                            end
                            else if (flg.fh_nil)
                            begin
                                ctl.st_we  = 1'b1;
                                ctl.st_val = ST_NOFREE;
                            end
                            else
                            begin
                                ctl.op     = OP_RD_FH;
                                state_next = S_TK_GROWP;
                            end
                        end
                        CMD_POP:
                        begin
                            if (flg.empty)
                            begin
                                ctl.st_we  = 1'b1;
                                ctl.st_val = ST_RANGE;
                            end
                            else
                            begin
                                ctl.op     = OP_RD_TOP;
                                state_next = S_POP_D;
                            end
                        end
                        CMD_ALLOC:
                        begin
                            if (flg.fh_nil)
                            begin
                                ctl.st_we  = 1'b1;
                                ctl.st_val = ST_NOFREE;
                            end
                            else
                            begin
                                ctl.op     = OP_RD_FH;
                                state_next = S_TK_GROW;
                            end
                        end
                        CMD_FSEG:
                        begin
                            ctl.op     = OP_RD_BASE;
                            state_next = S_SHR;
                        end
                        CMD_FSTK:
                        begin
                            ctl.op     = OP_FS_START;
                            state_next = S_FS_RD;
                        end
                        CMD_SIZE, CMD_PEEK:
                        begin
                            ctl.op     = OP_WALK_START;
                            state_next = S_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TK_OPEN:
            begin
                ctl.op     = OP_TAKE_OPEN;
                state_next = S_DONE;
            end
            S_TK_GROW:
            begin
                ctl.op     = OP_TAKE_GROW;
                state_next = S_DONE;
            end
            S_TK_GROWP:
            begin
                ctl.op     = OP_TAKE_GROW;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                ctl.op     = OP_PUSH;
                state_next = S_DONE;
            end
            S_POP_D:
            begin
                ctl.op     = OP_POP;
                state_next = S_POP_CK;
            end
            S_POP_CK:
            begin
                if (flg.empty)
                begin
                    ctl.op     = OP_RD_BASE;
                    state_next = S_SHR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHR:
            begin
                ctl.op     = OP_SHRINK;
                state_next = S_DONE;
            end
            S_FS_RD:
            begin
                ctl.op     = OP_RD_B;
                state_next = S_FS_WR;
            end
            S_FS_WR:
            begin
                ctl.op     = OP_FS_GIVE;
                state_next = flg.link_nil ? S_DONE : S_FS_RD;
            end
            S_WALK:
            begin
                ctl.op     = OP_WALK_ADD;
                state_next = S_WALK_NX;
            end
            S_WALK_NX:
            begin
                ctl.op     = OP_WALK_LINK;
                state_next = flg.link_nil ? S_WEND : S_WALK;
            end
            S_WEND:
            begin
                state_next = S_DONE;
                if (flg.cmd == CMD_SIZE)
                begin
                    ctl.op = OP_SET_DEP;
                end
                else if (flg.off_ge_n)
                begin
                    ctl.st_we  = 1'b1;
                    ctl.st_val = ST_RANGE;
                end
                else
                begin
                    ctl.op     = OP_WALK_START;
                    state_next = S_PK;
                end
            end
            S_PK:
            begin
                if (flg.pk_hit)
                begin
                    ctl.op     = OP_PK_RD;
                    state_next = S_PK_D;
                end
                else
                begin
                    ctl.op     = OP_PK_STEP;
                    state_next = S_PK_NX;
                end
            end
            S_PK_NX:
            begin
                ctl.op = OP_WALK_LINK;
                if (flg.link_nil)
                begin
                    ctl.st_we  = 1'b1;
                    ctl.st_val = ST_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PK;
                end
            end
            S_PK_D:
            begin
                ctl.op     = OP_PK_DATA;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

    `SSM_ASSERT_NEXT(a_start_decodes, (state_reg == S_IDLE && start), (state_reg == S_DEC), "accepted transfer not decoded")
    `SSM_ASSERT_NEXT(a_done_returns, (state_reg == S_DONE), (state_reg == S_IDLE && !busy), "finish did not return to idle")
    `SSM_ASSERT_NEXT(a_walk_pairs, (state_reg == S_WALK), (state_reg == S_WALK_NX), "walk step lost its link read")
    `SSM_ASSERT(a_init_no_finish, (state_reg == S_INIT) |-> (!ctl.finish && !ctl.st_we), "result raised during pool clearing")

endmodule

FILE: hw/rtl/segmented_stack_manager.sv
// top level of the segmented stack manager
// After reset the pool is cleared and chained one word per cycle with busy
// high. A command transfer is taken when start is high and busy low; its
// single result appears on result for exactly one cycle with done high and
// cannot be stalled. One command is in flight at a time and the pool memory,
// with its registered read, sets the pace: pop may also free its emptied
// segment, free stack and size walk every segment the stack holds, and peek
// runs the size walk and then steps over segments until it reaches the offset.
module segmented_stack_manager import ssm_pkg::*; #(
    parameter int SEG_WORDS    = 64,
    parameter int NUM_SEGMENTS = 64,
    parameter int NUM_STACKS   = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic done,
    output rsp_t result
);

    ctl_t ctl;
    flg_t flg;

    ssm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flg   (flg),
        .ctl   (ctl),
        .busy  (busy)
    );

    ssm_datapath #(
        .SEG_WORDS    (SEG_WORDS),
        .NUM_SEGMENTS (NUM_SEGMENTS),
        .NUM_STACKS   (NUM_STACKS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .flg     (flg),
        .done    (done),
        .result  (result)
    );

endmodule

FILE: tb/sv/tb_segmented_stack_manager.sv
// testbench for the segmented stack manager: queued command driver, result monitor and predictor
module tb_segmented_stack_manager;
    import ssm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SEG_WORDS    = 64;
    localparam int unsigned NUM_SEGMENTS = 64;
    localparam int unsigned NUM_STACKS   = 4;
    localparam int unsigned POOL_WORDS   = SEG_WORDS * NUM_SEGMENTS;
    localparam int unsigned NIL          = POOL_WORDS;
    localparam int          ITEMS        = 1700;

    logic clk;
    logic rst_n;
    logic start;
    req_t request;
    logic busy;
    logic done;
    rsp_t result;

    segmented_stack_manager #(
        .SEG_WORDS   (SEG_WORDS),
        .NUM_SEGMENTS(NUM_SEGMENTS),
        .NUM_STACKS  (NUM_STACKS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    bit [31:0] pool_mem [POOL_WORDS];
    bit [31:0] free_head;
    bit [31:0] top_ptr [NUM_STACKS];
    bit [31:0] seg_base [NUM_STACKS];
    bit        opened [NUM_STACKS];

    req_t pending_cmds [$];
    rsp_t expected_rsps [$];
    int   errors;
    int   sent;
    logic took;

    function automatic bit [31:0] pool_rd(bit [31:0] a);
        return (a < POOL_WORDS) ? pool_mem[a] : 32'd0;
    endfunction

    function automatic void pool_wr(bit [31:0] a, bit [31:0] v);
        if (a < POOL_WORDS)
            pool_mem[a] = v;
    endfunction

    function automatic bit [31:0] seg_start(bit [31:0] a);
        return (a / SEG_WORDS) * SEG_WORDS;
    endfunction

    function automatic bit [31:0] link_at(bit [31:0] b);
        bit [31:0] l;
        l = pool_rd(b);
        return (l < POOL_WORDS) ? l : NIL;
    endfunction

    function automatic bit take_seg(output bit [31:0] sg);
        sg = 0;
        if (free_head >= POOL_WORDS)
            return 0;
        sg = free_head;
        free_head = link_at(free_head);
        return 1;
    endfunction

    function automatic void give_seg(bit [31:0] sg);
        pool_wr(sg, free_head);
        free_head = sg;
    endfunction

    function automatic bit [31:0] walk_depth(int s);
        bit [31:0] p, n, b;
        p = top_ptr[s];
        n = 0;
        for (int i = 0; i < NUM_SEGMENTS && p != NIL; i++)
        begin
            b = seg_start(p);
            n += p - b;
            p = link_at(b);
        end
        return n;
    endfunction

    function automatic bit grow_stack(int s);
        bit [31:0] sg;
        if (!take_seg(sg))
            return 0;
        pool_wr(sg, seg_base[s] + SEG_WORDS - 1);
        seg_base[s] = sg;
        top_ptr[s] = sg;
        return 1;
    endfunction

    function automatic void shrink_stack(int s);
        bit [31:0] b, l;
        b = seg_base[s];
        l = link_at(b);
        if (l == NIL)
            return;
        give_seg(b);
        top_ptr[s] = l;
        seg_base[s] = seg_start(l);
    endfunction

    function automatic void reset_model();
        foreach (pool_mem[i])
            pool_mem[i] = 0;
        for (int i = 0; i < NUM_SEGMENTS; i++)
            pool_mem[i * SEG_WORDS] = (i + 1 < NUM_SEGMENTS) ? (i + 1) * SEG_WORDS : NIL;
        free_head = 0;
        for (int i = 0; i < NUM_STACKS; i++)
        begin
            top_ptr[i] = 0;
            seg_base[i] = 0;
            opened[i] = 0;
        end
    endfunction

    function automatic rsp_t predict_stack_op(req_t r);
        rsp_t      o;
        int        s;
        bit [31:0] sg, b, l, p, off;
        o = '0;
        s = r.stack_id;
        off = r.depth_offset;
        if (s >= NUM_STACKS)
            o.status = ST_CLOSED;
        else if (r.command == CMD_OPEN)
        begin
            if (!opened[s])
            begin
                if (take_seg(sg))
                begin
                    pool_wr(sg, NIL);
                    seg_base[s] = sg;
                    top_ptr[s] = sg;
                    opened[s] = 1;
                end
                else
                    o.status = ST_NOFREE;
            end
        end
        else if (!opened[s])
            o.status = ST_CLOSED;
        else
        begin
            case (r.command)
                CMD_PUSH:
                begin
                    if (top_ptr[s] == seg_base[s] + SEG_WORDS - 1 && !grow_stack(s))
                        o.status = ST_NOFREE;
                    else
                    begin
                        top_ptr[s] += 1;
                        pool_wr(top_ptr[s], r.push_value);
                    end
                end
                CMD_POP:
                begin
                    if (top_ptr[s] == seg_base[s])
                        o.status = ST_RANGE;
                    else
                    begin
                        o.read_value = pool_rd(top_ptr[s]);
                        top_ptr[s] -= 1;
                        if (top_ptr[s] == seg_base[s])
                            shrink_stack(s);
                    end
                end
                CMD_ALLOC:
                begin
                    if (!grow_stack(s))
                        o.status = ST_NOFREE;
                end
                CMD_FSEG:
                    shrink_stack(s);
                CMD_FSTK:
                begin
                    b = seg_base[s];
                    for (int i = 0; i < NUM_SEGMENTS && b != NIL; i++)
                    begin
                        l = link_at(b);
                        give_seg(b);
                        b = (l == NIL) ? NIL : seg_start(l);
                    end
                    top_ptr[s] = 0;
                    seg_base[s] = 0;
                    opened[s] = 0;
                end
                CMD_SIZE:
                    o.stack_depth = 13'(walk_depth(s));
                default:
                begin
                    if (off >= walk_depth(s))
                        o.status = ST_RANGE;
                    else
                    begin
                        p = top_ptr[s];
                        b = seg_base[s];
                        for (int i = 0; i < NUM_SEGMENTS && p - b <= off; i++)
                        begin
                            off -= p - b;
                            p = link_at(b);
                            if (p == NIL)
                                break;
                            b = seg_start(p);
                        end
                        if (p == NIL || p - b <= off)
                            o.status = ST_RANGE;
                        else
                            o.read_value = pool_rd(p - off);
                    end
                end
            endcase
        end
        return o;
    endfunction

    function automatic req_t mk(logic [2:0] c, logic [1:0] s, logic [31:0] v, logic [11:0] off);
        req_t r;
        r.command = c;
        r.stack_id = s;
        r.push_value = v;
        r.depth_offset = off;
        return r;
    endfunction

    function automatic logic [11:0] rand_offset();
        return ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 150)) : 12'($urandom);
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
    endtask

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // command driver
    always @(negedge clk)
    begin
        logic idle;
        int   pct;
        if (rst_n && (!start || took))
        begin
            pct = (sent < ITEMS / 3) ? 10 : (sent < 2 * ITEMS / 3) ? 79 : 0;
            idle = ($urandom_range(0, 99) < pct);
            if (pending_cmds.size() > 0 && !idle)
            begin
                request <= pending_cmds.pop_front();
                start <= 1'b1;
                sent++;
            end
            else
                start <= 1'b0;
        end
    end

    // transfer monitor and result check
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    $display("unexpected result at %0t", $realtime);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (result.read_value !== want.read_value)
                        report_mismatch("read_value", result.read_value, want.read_value);
                    if (result.stack_depth !== want.stack_depth)
                        report_mismatch("stack_depth", result.stack_depth, want.stack_depth);
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                end
            end
            took <= start && !busy;
            if (start && !busy)
                expected_rsps.push_back(predict_stack_op(request));
        end
        else
            took <= 1'b0;
    end

    initial
    begin
        int mode, n, s;
        rst_n = 0;
        start = 0;
        request = '0;
        took = 0;
        errors = 0;
        sent = 0;
        reset_model();

        pending_cmds.push_back(mk(CMD_OPEN, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_OPEN, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_PUSH, 1, 32'h1234, 0));
        pending_cmds.push_back(mk(CMD_POP, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_PEEK, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_SIZE, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_PUSH, 0, 32'h0, 0));
        pending_cmds.push_back(mk(CMD_PUSH, 0, 32'hFFFF_FFFF, 12'hFFF));
        pending_cmds.push_back(mk(CMD_PEEK, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_PEEK, 0, 0, 1));
        pending_cmds.push_back(mk(CMD_PEEK, 0, 0, 12'hFFF));
        pending_cmds.push_back(mk(CMD_ALLOC, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_SIZE, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_PEEK, 0, 0, 5));
        pending_cmds.push_back(mk(CMD_FSEG, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_FSEG, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_POP, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_POP, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_POP, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_OPEN, 3, 0, 0));
        pending_cmds.push_back(mk(CMD_FSTK, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_SIZE, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_PEEK, 2, 0, 12'hFFF));

        // random part: bursts that cross segments and drain the free list, plus mixed noise
        while (pending_cmds.size() < ITEMS)
        begin
            mode = $urandom_range(0, 99);
            s = $urandom_range(0, 3);
            if (mode < 6)
            begin
                pending_cmds.push_back(mk(CMD_OPEN, s, 0, 0));
                n = $urandom_range(60, 140);
                repeat (n) pending_cmds.push_back(mk(CMD_PUSH, s, $urandom, rand_offset()));
            end
            else if (mode < 9)
            begin
                pending_cmds.push_back(mk(CMD_OPEN, s, 0, 0));
                n = $urandom_range(20, 70);
                repeat (n) pending_cmds.push_back(mk(CMD_ALLOC, s, $urandom, 0));
            end
            else if (mode < 12)
            begin
                n = $urandom_range(30, 140);
                repeat (n) pending_cmds.push_back(mk(CMD_POP, s, $urandom, 0));
            end
            else
            begin
                n = $urandom_range(0, 99);
                pending_cmds.push_back(mk(
                    (n < 40) ? CMD_PUSH : (n < 60) ? CMD_POP : (n < 70) ? CMD_PEEK :
                    (n < 78) ? CMD_SIZE : (n < 86) ? CMD_OPEN : (n < 91) ? CMD_ALLOC :
                    (n < 96) ? CMD_FSEG : CMD_FSTK,
                    s, $urandom, rand_offset()));
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        wait (pending_cmds.size() == 0 && start == 1'b0);
        wait (expected_rsps.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_ram.sv
hw/rtl/ssm_datapath.sv
hw/rtl/ssm_ctrl.sv
hw/rtl/segmented_stack_manager.sv
tb/sv/tb_segmented_stack_manager.sv
